[design/lsdm_pkg.sv]
// ----------------------------------------------------------------------------
// Lens distortion point map package
// Shared types, widths and constants of the distortion pipeline.
// ----------------------------------------------------------------------------
package lsdm_pkg;

  // Fixed-point formats
  localparam int COORD_FRAC_BITS = 4;
  localparam int NORM_FRAC       = 20;
  localparam int FOCAL_FRAC      = 8;

  // Field and datapath widths
  localparam int COORD_W  = 16;
  localparam int FOCAL_W  = 24;
  localparam int COEF_W   = 24;
  localparam int CFG_W    = 32;
  localparam int REG_IDX_W = 3;
  localparam int DIFF_W   = 18;
  localparam int MAG_W    = 17;
  localparam int QUO_W    = 23;
  localparam int NORM_W   = 24;
  localparam int CORR_W   = 35;

  // Clamp limits
  localparam logic [QUO_W-1:0] NORM_LIMIT = QUO_W'(1) << 22;

  // Pipeline depths of the three sections
  localparam int DIV_DEPTH  = QUO_W + 2;
  localparam int POLY_DEPTH = 11;
  localparam int PROJ_DEPTH = 3;

  // Register reset values
  localparam logic [FOCAL_W-1:0] FOCAL_RESET = FOCAL_W'(128000);

  typedef enum logic [REG_IDX_W-1:0] {
    CFG_FOCAL_X   = 3'd0,
    CFG_FOCAL_Y   = 3'd1,
    CFG_PRINCIPAL = 3'd2,
    CFG_K1        = 3'd3,
    CFG_K2        = 3'd4,
    CFG_K3        = 3'd5,
    CFG_P1        = 3'd6,
    CFG_P2        = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] undist_x;
    logic signed [COORD_W-1:0] undist_y;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] dist_x;
    logic signed [COORD_W-1:0] dist_y;
    logic                      clipped;
  } out_t;

  // Normalized point between divider and polynomial section
  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic                     clip;
  } norm_t;

  // Corrected point between polynomial and projection section
  typedef struct packed {
    logic signed [CORR_W-1:0] xc;
    logic signed [CORR_W-1:0] yc;
    logic                     clip;
  } corr_t;

  // Configuration as seen by the datapath; focal lengths never zero
  typedef struct packed {
    logic        [FOCAL_W-1:0] focal_x;
    logic        [FOCAL_W-1:0] focal_y;
    logic        [COORD_W-1:0] centre_x;
    logic        [COORD_W-1:0] centre_y;
    logic signed [COEF_W-1:0]  k1;
    logic signed [COEF_W-1:0]  k2;
    logic signed [COEF_W-1:0]  k3;
    logic signed [COEF_W-1:0]  p1;
    logic signed [COEF_W-1:0]  p2;
  } cfg_t;

endpackage

[design/lsdm_div.sv]
// ----------------------------------------------------------------------------
// Normalizing divider
// Centers both coordinates and divides by the focal lengths with a
// restoring divider that resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module lsdm_div #(
  parameter int CoordFracBits = lsdm_pkg::COORD_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsdm_pkg::cfg_t    cfg_i,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  lsdm_pkg::in_t     up_data_i,
  output logic              dn_valid_o,
  input  logic              dn_ready_i,
  output lsdm_pkg::norm_t   dn_data_o
);

  localparam int Shift = lsdm_pkg::NORM_FRAC + lsdm_pkg::FOCAL_FRAC - CoordFracBits;
  localparam int QW    = lsdm_pkg::QUO_W;
  localparam int MW    = lsdm_pkg::MAG_W;
  localparam int DW    = lsdm_pkg::DIFF_W;
  localparam int FW    = lsdm_pkg::FOCAL_W;
  localparam int XW    = lsdm_pkg::NORM_W;
  localparam int NW    = MW + Shift + 1;
  localparam int Depth = lsdm_pkg::DIV_DEPTH;

  logic [Depth-1:0] vld_q;
  logic             en;

  // Advance the whole section when the last stage is free or drains
  assign en         = !vld_q[Depth-1] || dn_ready_i;
  assign up_ready_o = en;
  assign dn_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], up_valid_i};
    end
  end

  // Lane inputs: lane 0 is x, lane 1 is y
  logic signed [lsdm_pkg::COORD_W-1:0] u [2];
  logic        [lsdm_pkg::COORD_W-1:0] c [2];
  logic        [FW-1:0]                f [2];

  assign u[0] = up_data_i.undist_x;
  assign u[1] = up_data_i.undist_y;
  assign c[0] = cfg_i.centre_x;
  assign c[1] = cfg_i.centre_y;
  assign f[0] = cfg_i.focal_x;
  assign f[1] = cfg_i.focal_y;

  logic [FW-1:0] r_q   [2][QW];
  logic [QW-1:0] nlo_q [2][QW];
  logic [QW-1:0] q_q   [2][QW+1];
  logic          neg_q [2][QW+1];
  logic          ovf_q [2][QW+1];
  logic signed [XW-1:0] x_q [2];
  logic          big   [2];
  logic          clip_q;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [DW-1:0] d;
    logic [MW-1:0]        mag;
    logic [NW-1:0]        num;
    logic [FW-1:0]        hi;
    logic [QW-1:0]        mq;
    logic signed [XW-1:0] val;

    // Center, take the magnitude and add half the divisor for rounding
    always_comb begin
      d   = {{(DW - lsdm_pkg::COORD_W){u[l][lsdm_pkg::COORD_W-1]}}, u[l]}
            - {{(DW - lsdm_pkg::COORD_W){1'b0}}, c[l]};
      mag = d[DW-1] ? MW'(-d) : MW'(d);
      num = (NW'(mag) << Shift) + NW'(f[l] >> 1);
      hi  = FW'(num[NW-1:QW]);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[l][0]   <= hi;
        nlo_q[l][0] <= num[QW-1:0];
        q_q[l][0]   <= '0;
        neg_q[l][0] <= d[DW-1];
        ovf_q[l][0] <= hi >= f[l];
      end
    end

    // One restoring step per stage
    for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [FW:0] t;
      logic        ge;

      always_comb begin
        t  = {r_q[l][k-1], nlo_q[l][k-1][QW-k]};
        ge = t >= {1'b0, f[l]};
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          q_q[l][k]   <= {q_q[l][k-1][QW-2:0], ge};
          neg_q[l][k] <= neg_q[l][k-1];
          ovf_q[l][k] <= ovf_q[l][k-1];
        end
      end

      if (k < QW) begin : g_keep
        always_ff @(posedge clk_i) begin
          if (en) begin
            r_q[l][k]   <= ge ? FW'(t - {1'b0, f[l]}) : FW'(t);
            nlo_q[l][k] <= nlo_q[l][k-1];
          end
        end
      end
    end

    // Clamp the quotient and restore the sign
    always_comb begin
      big[l] = ovf_q[l][QW] || (q_q[l][QW] > lsdm_pkg::NORM_LIMIT);
      mq     = big[l] ? lsdm_pkg::NORM_LIMIT : q_q[l][QW];
      val    = signed'(XW'(mq));
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        x_q[l] <= neg_q[l][QW] ? -val : val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      clip_q <= big[0] || big[1];
    end
  end

  assign dn_data_o.x    = x_q[0];
  assign dn_data_o.y    = x_q[1];
  assign dn_data_o.clip = clip_q;

endmodule

[design/lsdm_poly.sv]
// ----------------------------------------------------------------------------
// Distortion polynomial
// Evaluates the radial and tangential terms on the normalized point and
// clamps the corrected coordinates.
// ----------------------------------------------------------------------------
module lsdm_poly (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsdm_pkg::cfg_t    cfg_i,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  lsdm_pkg::norm_t   up_data_i,
  output logic              dn_valid_o,
  input  logic              dn_ready_i,
  output lsdm_pkg::corr_t   dn_data_o
);

  localparam int NF    = lsdm_pkg::NORM_FRAC;
  localparam int Half  = 1 << (NF - 1);
  localparam int One   = 1 << NF;
  localparam int XW    = lsdm_pkg::NORM_W;
  localparam int SQW   = 48;
  localparam int SQSW  = 49;
  localparam int R2W   = 27;
  localparam int XYW   = 26;
  localparam int TW    = 29;
  localparam int R4PW  = 54;
  localparam int R4W   = 32;
  localparam int R6PW  = 59;
  localparam int R6W   = 37;
  localparam int K1PW  = 51;
  localparam int K2PW  = 56;
  localparam int K3PW  = 61;
  localparam int TAPW  = 50;
  localparam int TBPW  = 53;
  localparam int TSW   = 55;
  localparam int TXW   = 36;
  localparam int SUMW  = 63;
  localparam int RADW  = 44;
  localparam int RHW   = 24;
  localparam int PHW   = 48;
  localparam int PLW   = 45;
  localparam int XPW   = 68;
  localparam int XRW   = 48;
  localparam int CSW   = 49;
  localparam int CW    = lsdm_pkg::CORR_W;
  localparam longint CorrLimit = 64'sd1 <<< 33;
  localparam int Depth = lsdm_pkg::POLY_DEPTH;

  logic [Depth-1:0] vld_q;
  logic             en;

  assign en         = !vld_q[Depth-1] || dn_ready_i;
  assign up_ready_o = en;
  assign dn_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], up_valid_i};
    end
  end

  // Point travels up to the scaling stage, clip flag along every stage
  logic signed [XW-1:0] x_q [8];
  logic signed [XW-1:0] y_q [8];
  logic                 clip_q [10];

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0]    <= up_data_i.x;
      y_q[0]    <= up_data_i.y;
      clip_q[0] <= up_data_i.clip;
      for (int s = 1; s < 8; s++) begin
        x_q[s] <= x_q[s-1];
        y_q[s] <= y_q[s-1];
      end
      for (int s = 1; s < 10; s++) begin
        clip_q[s] <= clip_q[s-1];
      end
    end
  end

  // Stage 0: squares and cross product
  logic signed [SQW-1:0] pxx_q, pyy_q, pxy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxx_q <= SQW'(up_data_i.x) * SQW'(up_data_i.x);
      pyy_q <= SQW'(up_data_i.y) * SQW'(up_data_i.y);
      pxy_q <= SQW'(up_data_i.x) * SQW'(up_data_i.y);
    end
  end

  // Stage 1: round r2, x*x, y*y and x*y
  logic signed [SQSW-1:0] s_r2, s_xx, s_yy, s_xy;
  logic signed [R2W-1:0]  r2_1_q, xx_q, yy_q;
  logic signed [XYW-1:0]  xy_1_q;

  always_comb begin
    s_r2 = SQSW'(pxx_q) + SQSW'(pyy_q) + SQSW'(Half);
    s_xx = SQSW'(pxx_q) + SQSW'(Half);
    s_yy = SQSW'(pyy_q) + SQSW'(Half);
    s_xy = SQSW'(pxy_q) + SQSW'(Half);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_1_q <= R2W'(s_r2 >>> NF);
      xx_q   <= R2W'(s_xx >>> NF);
      yy_q   <= R2W'(s_yy >>> NF);
      xy_1_q <= XYW'(s_xy >>> NF);
    end
  end

  // Stage 2: r2 squared, tangential sums
  logic signed [R4PW-1:0] pr4_q;
  logic signed [TW-1:0]   ta_2_q, tb_2_q;
  logic signed [R2W-1:0]  r2_2_q;
  logic signed [XYW-1:0]  xy_2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr4_q  <= R4PW'(r2_1_q) * R4PW'(r2_1_q);
      ta_2_q <= TW'(r2_1_q) + TW'(xx_q) + TW'(xx_q);
      tb_2_q <= TW'(r2_1_q) + TW'(yy_q) + TW'(yy_q);
      r2_2_q <= r2_1_q;
      xy_2_q <= xy_1_q;
    end
  end

  // Stage 3: round r4
  logic signed [R4PW-1:0] s_r4;
  logic signed [R4W-1:0]  r4_q;
  logic signed [TW-1:0]   ta_3_q, tb_3_q;
  logic signed [R2W-1:0]  r2_3_q;
  logic signed [XYW-1:0]  xy_3_q;

  assign s_r4 = pr4_q + R4PW'(Half);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r4_q   <= R4W'(s_r4 >>> NF);
      ta_3_q <= ta_2_q;
      tb_3_q <= tb_2_q;
      r2_3_q <= r2_2_q;
      xy_3_q <= xy_2_q;
    end
  end

  // Stage 4: r6 product, coefficient and tangential products
  logic signed [R6PW-1:0] pr6_q;
  logic signed [K1PW-1:0] pk1_4_q;
  logic signed [K2PW-1:0] pk2_4_q;
  logic signed [TAPW-1:0] pa1_q, pa2_q;
  logic signed [TBPW-1:0] pb1_q, pb2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr6_q   <= R6PW'(r4_q) * R6PW'(r2_3_q);
      pk1_4_q <= K1PW'(cfg_i.k1) * K1PW'(r2_3_q);
      pk2_4_q <= K2PW'(cfg_i.k2) * K2PW'(r4_q);
      pa1_q   <= TAPW'(cfg_i.p1) * TAPW'(xy_3_q);
      pa2_q   <= TAPW'(cfg_i.p2) * TAPW'(xy_3_q);
      pb1_q   <= TBPW'(cfg_i.p2) * TBPW'(ta_3_q);
      pb2_q   <= TBPW'(cfg_i.p1) * TBPW'(tb_3_q);
    end
  end

  // Stage 5: round r6 and the tangential terms
  logic signed [R6PW-1:0] s_r6;
  logic signed [TSW-1:0]  s_tx, s_ty;
  logic signed [R6W-1:0]  r6_q;
  logic signed [TXW-1:0]  tx_q [5];
  logic signed [TXW-1:0]  ty_q [5];
  logic signed [K1PW-1:0] pk1_5_q;
  logic signed [K2PW-1:0] pk2_5_q;

  always_comb begin
    s_r6 = pr6_q + R6PW'(Half);
    s_tx = TSW'(pa1_q) + TSW'(pa1_q) + TSW'(pb1_q) + TSW'(Half);
    s_ty = TSW'(pb2_q) + TSW'(pa2_q) + TSW'(pa2_q) + TSW'(Half);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r6_q    <= R6W'(s_r6 >>> NF);
      tx_q[0] <= TXW'(s_tx >>> NF);
      ty_q[0] <= TXW'(s_ty >>> NF);
      pk1_5_q <= pk1_4_q;
      pk2_5_q <= pk2_4_q;
      for (int s = 1; s < 5; s++) begin
        tx_q[s] <= tx_q[s-1];
        ty_q[s] <= ty_q[s-1];
      end
    end
  end

  // Stage 6: k3 term
  logic signed [K3PW-1:0] pk3_q;
  logic signed [K1PW-1:0] pk1_6_q;
  logic signed [K2PW-1:0] pk2_6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk3_q   <= K3PW'(cfg_i.k3) * K3PW'(r6_q);
      pk1_6_q <= pk1_5_q;
      pk2_6_q <= pk2_5_q;
    end
  end

  // Stage 7: radial factor, one plus the rounded coefficient sum
  logic signed [SUMW-1:0] s_k;
  logic signed [RADW-1:0] rad_q;

  assign s_k = SUMW'(pk1_6_q) + SUMW'(pk2_6_q) + SUMW'(pk3_q) + SUMW'(Half);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= RADW'(s_k >>> NF) + RADW'(One);
    end
  end

  // Stage 8: scale the point by the radial factor in two partial products
  logic signed [RHW-1:0] rhi;
  logic signed [PLW-1:0] rlo;
  logic signed [PHW-1:0] pxh_q, pyh_q;
  logic signed [PLW-1:0] pxl_q, pyl_q;

  always_comb begin
    rhi = RHW'(rad_q >>> NF);
    rlo = signed'(PLW'(rad_q[NF-1:0]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxh_q <= PHW'(x_q[7]) * PHW'(rhi);
      pyh_q <= PHW'(y_q[7]) * PHW'(rhi);
      pxl_q <= PLW'(x_q[7]) * rlo;
      pyl_q <= PLW'(y_q[7]) * rlo;
    end
  end

  // Stage 9: combine partial products and round
  logic signed [XPW-1:0] s_xr, s_yr;
  logic signed [XRW-1:0] xr_q, yr_q;

  always_comb begin
    s_xr = (XPW'(pxh_q) <<< NF) + XPW'(pxl_q) + XPW'(Half);
    s_yr = (XPW'(pyh_q) <<< NF) + XPW'(pyl_q) + XPW'(Half);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xr_q <= XRW'(s_xr >>> NF);
      yr_q <= XRW'(s_yr >>> NF);
    end
  end

  // Stage 10: add tangential terms and clamp
  logic signed [CSW-1:0] cx, cy;
  logic signed [CW-1:0]  cx_c, cy_c;
  logic                  clx, cly;
  logic signed [CW-1:0]  xc_q, yc_q;
  logic                  clip_out_q;

  always_comb begin
    cx = CSW'(xr_q) + CSW'(tx_q[4]);
    cy = CSW'(yr_q) + CSW'(ty_q[4]);
    clx = 1'b0;
    cly = 1'b0;
    cx_c = CW'(cx);
    cy_c = CW'(cy);
    priority if (cx > CSW'(CorrLimit)) begin
      cx_c = CW'(CorrLimit);
      clx  = 1'b1;
    end else if (cx < -CSW'(CorrLimit)) begin
      cx_c = -CW'(CorrLimit);
      clx  = 1'b1;
    end else begin
      cx_c = CW'(cx);
    end
    priority if (cy > CSW'(CorrLimit)) begin
      cy_c = CW'(CorrLimit);
      cly  = 1'b1;
    end else if (cy < -CSW'(CorrLimit)) begin
      cy_c = -CW'(CorrLimit);
      cly  = 1'b1;
    end else begin
      cy_c = CW'(cy);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xc_q       <= cx_c;
      yc_q       <= cy_c;
      clip_out_q <= clip_q[9] || clx || cly;
    end
  end

  assign dn_data_o.xc   = xc_q;
  assign dn_data_o.yc   = yc_q;
  assign dn_data_o.clip = clip_out_q;

endmodule

[design/lsdm_proj.sv]
// ----------------------------------------------------------------------------
// Projection to pixels
// Multiplies the corrected point by the focal lengths, adds the centre and
// saturates to the coordinate range. The last stage is the output register.
// ----------------------------------------------------------------------------
module lsdm_proj #(
  parameter int CoordFracBits = lsdm_pkg::COORD_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsdm_pkg::cfg_t    cfg_i,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  lsdm_pkg::corr_t   up_data_i,
  output logic              dn_valid_o,
  input  logic              dn_ready_i,
  output lsdm_pkg::out_t    dn_data_o
);

  localparam int Shift = lsdm_pkg::NORM_FRAC + lsdm_pkg::FOCAL_FRAC - CoordFracBits;
  localparam int CW    = lsdm_pkg::CORR_W;
  localparam int FW    = lsdm_pkg::FOCAL_W;
  localparam int OW    = lsdm_pkg::COORD_W;
  localparam int LoW   = 18;
  localparam int HiW   = CW - LoW;
  localparam int PPW   = 42;
  localparam int SW    = 62;
  localparam int PW    = SW - Shift + 1;
  localparam longint HalfP  = 64'sd1 <<< (Shift - 1);
  localparam longint SatMax = 64'sd32767;
  localparam longint SatMin = -64'sd32768;
  localparam int Depth = lsdm_pkg::PROJ_DEPTH;

  logic [Depth-1:0] vld_q;
  logic             en;

  assign en         = !vld_q[Depth-1] || dn_ready_i;
  assign up_ready_o = en;
  assign dn_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], up_valid_i};
    end
  end

  logic signed [CW-1:0] c [2];
  logic        [FW-1:0] f [2];
  logic        [OW-1:0] ctr [2];
  logic signed [OW-1:0] res_q [2];
  logic                 sat [2];
  logic                 clip_q [2];

  assign c[0]   = up_data_i.xc;
  assign c[1]   = up_data_i.yc;
  assign f[0]   = cfg_i.focal_x;
  assign f[1]   = cfg_i.focal_y;
  assign ctr[0] = cfg_i.centre_x;
  assign ctr[1] = cfg_i.centre_y;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [HiW-1:0] chi;
    logic signed [PPW-1:0] ph_q;
    logic        [PPW-1:0] pl_q;
    logic signed [SW-1:0]  s;
    logic signed [PW-1:0]  p_q;

    // Stage 0: split the corrected value into two partial products
    assign chi = c[l][CW-1:LoW];

    always_ff @(posedge clk_i) begin
      if (en) begin
        ph_q <= PPW'(chi) * signed'(PPW'(f[l]));
        pl_q <= PPW'(c[l][LoW-1:0]) * PPW'(f[l]);
      end
    end

    // Stage 1: combine, round to pixel fraction and add the centre
    assign s = (SW'(ph_q) <<< LoW) + signed'(SW'(pl_q)) + SW'(HalfP);

    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q <= PW'(s >>> Shift) + signed'(PW'(ctr[l]));
      end
    end

    // Stage 2: saturate into the output register
    always_comb begin
      sat[l] = (p_q > PW'(SatMax)) || (p_q < PW'(SatMin));
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        priority if (p_q > PW'(SatMax)) begin
          res_q[l] <= OW'(SatMax);
        end else if (p_q < PW'(SatMin)) begin
          res_q[l] <= OW'(SatMin);
        end else begin
          res_q[l] <= OW'(p_q);
        end
      end
    end
  end

  // Carry the clip flag alongside
  logic clip_out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      clip_q[0]  <= up_data_i.clip;
      clip_q[1]  <= clip_q[0];
      clip_out_q <= clip_q[1] || sat[0] || sat[1];
    end
  end

  assign dn_data_o.dist_x  = res_q[0];
  assign dn_data_o.dist_y  = res_q[1];
  assign dn_data_o.clipped = clip_out_q;

endmodule

[design/lens_distortion_point_map.sv]
// Throughput: one point per cycle while results are taken at the output; the
// normalizing divider resolves one quotient bit per stage, so all 39 stages are
// pipelined and each takes a new point per cycle unless the output stalls.
// Reset: asynchronous, active low; clears all valid bits and loads the register
// defaults (focal 500.0 pixels, centre zero, all coefficients zero).
// ----------------------------------------------------------------------------
// Lens distortion point map
// Maps an undistorted pixel point through the radial and tangential lens model.
// ----------------------------------------------------------------------------
module lens_distortion_point_map #(
  parameter int CoordFracBits = lsdm_pkg::COORD_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lsdm_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lsdm_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lsdm_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lsdm_pkg::out_t                      out_data_o
);

  localparam int FW = lsdm_pkg::FOCAL_W;
  localparam int KW = lsdm_pkg::COEF_W;
  localparam int TotalDepth = lsdm_pkg::DIV_DEPTH + lsdm_pkg::POLY_DEPTH
                              + lsdm_pkg::PROJ_DEPTH;
  localparam int OccW = $clog2(TotalDepth + 1);

  // Configuration registers
  logic [FW-1:0]              focal_x_q, focal_y_q;
  logic [lsdm_pkg::CFG_W-1:0] principal_q;
  logic [KW-1:0]              k1_q, k2_q, k3_q, p1_q, p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q   <= lsdm_pkg::FOCAL_RESET;
      focal_y_q   <= lsdm_pkg::FOCAL_RESET;
      principal_q <= '0;
      k1_q        <= '0;
      k2_q        <= '0;
      k3_q        <= '0;
      p1_q        <= '0;
      p2_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (lsdm_pkg::cfg_idx_e'(cfg_idx_i))
        lsdm_pkg::CFG_FOCAL_X:   focal_x_q   <= cfg_data_i[FW-1:0];
        lsdm_pkg::CFG_FOCAL_Y:   focal_y_q   <= cfg_data_i[FW-1:0];
        lsdm_pkg::CFG_PRINCIPAL: principal_q <= cfg_data_i;
        lsdm_pkg::CFG_K1:        k1_q        <= cfg_data_i[KW-1:0];
        lsdm_pkg::CFG_K2:        k2_q        <= cfg_data_i[KW-1:0];
        lsdm_pkg::CFG_K3:        k3_q        <= cfg_data_i[KW-1:0];
        lsdm_pkg::CFG_P1:        p1_q        <= cfg_data_i[KW-1:0];
        lsdm_pkg::CFG_P2:        p2_q        <= cfg_data_i[KW-1:0];
        default: ;
      endcase
    end
  end

  // Datapath view of the configuration; a zero focal length acts as one LSB
  lsdm_pkg::cfg_t cfg;

  always_comb begin
    cfg.focal_x  = (focal_x_q == '0) ? FW'(1) : focal_x_q;
    cfg.focal_y  = (focal_y_q == '0) ? FW'(1) : focal_y_q;
    cfg.centre_x = principal_q[31:16];
    cfg.centre_y = principal_q[15:0];
    cfg.k1       = signed'(k1_q);
    cfg.k2       = signed'(k2_q);
    cfg.k3       = signed'(k3_q);
    cfg.p1       = signed'(p1_q);
    cfg.p2       = signed'(p2_q);
  end

  // Section links
  logic              div_valid, div_ready;
  lsdm_pkg::norm_t   div_data;
  logic              poly_valid, poly_ready;
  lsdm_pkg::corr_t   poly_data;

  lsdm_div #(
    .CoordFracBits(CoordFracBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .up_valid_i (in_valid_i),
    .up_ready_o (in_ready_o),
    .up_data_i  (in_data_i),
    .dn_valid_o (div_valid),
    .dn_ready_i (div_ready),
    .dn_data_o  (div_data)
  );

  lsdm_poly u_poly (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .up_valid_i (div_valid),
    .up_ready_o (div_ready),
    .up_data_i  (div_data),
    .dn_valid_o (poly_valid),
    .dn_ready_i (poly_ready),
    .dn_data_o  (poly_data)
  );

  lsdm_proj #(
    .CoordFracBits(CoordFracBits)
  ) u_proj (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .up_valid_i (poly_valid),
    .up_ready_o (poly_ready),
    .up_data_i  (poly_data),
    .dn_valid_o (out_valid_o),
    .dn_ready_i (out_ready_i),
    .dn_data_o  (out_data_o)
  );

  // Track points in flight
  logic            in_xfer, out_xfer;
  logic [OccW-1:0] occ_q, occ_d;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (in_xfer && !out_xfer) begin
      occ_d = occ_q + OccW'(1);
    end else if (out_xfer && !in_xfer) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Never more points in flight than pipeline stages
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(TotalDepth))
    else $error("more transactions in flight than pipeline stages");

  // No result without an accepted point behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> !out_valid_o)
    else $error("result shown with no transaction in flight");

  // Input only stalls when the output holds a result that is not taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output drains");

endmodule

[dv/lsdm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lens distortion checker
// Watches the point and result channels and the register write port, predicts
// each distorted point with a fixed-point model and compares in order.
// ----------------------------------------------------------------------------
module lsdm_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsdm_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [lsdm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  lsdm_pkg::in_t                  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  lsdm_pkg::out_t                 out_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             points_seen_o,
  output int                             clipped_seen_o
);

  localparam int ProjShift = lsdm_pkg::NORM_FRAC + lsdm_pkg::FOCAL_FRAC
                             - lsdm_pkg::COORD_FRAC_BITS;

  logic [lsdm_pkg::FOCAL_W-1:0] focal_x_q, focal_y_q;
  logic [lsdm_pkg::CFG_W-1:0]   centre_q;
  logic [lsdm_pkg::COEF_W-1:0]  coef_q [5];
  lsdm_pkg::out_t               expected_points [$];

  // Round to nearest, ties toward +inf; arithmetic shift floors
  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint norm_coord(longint d, logic [lsdm_pkg::FOCAL_W-1:0] f,
                                       ref bit clip);
    longint num, mag, q, fl;
    fl = (f == 0) ? 1 : longint'(f);
    num = d * (longint'(1) <<< ProjShift);
    mag = (num < 0) ? -num : num;
    q = (mag + fl / 2) / fl;
    if (q > (longint'(1) <<< 22)) begin
      q = longint'(1) <<< 22;
      clip = 1;
    end
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [lsdm_pkg::COORD_W-1:0] project_coord(
      longint c, logic [lsdm_pkg::FOCAL_W-1:0] f, longint ctr, ref bit clip);
    longint lim, p, fl;
    lim = longint'(1) <<< 33;
    fl = (f == 0) ? 1 : longint'(f);
    if (c > lim) begin c = lim; clip = 1; end
    if (c < -lim) begin c = -lim; clip = 1; end
    p = round_half_up(c * fl, ProjShift) + ctr;
    if (p > 32767) begin p = 32767; clip = 1; end
    if (p < -32768) begin p = -32768; clip = 1; end
    return p[lsdm_pkg::COORD_W-1:0];
  endfunction

  function automatic lsdm_pkg::out_t distort_point(lsdm_pkg::in_t pt);
    bit clip;
    longint cx, cy, k1, k2, k3, p1, p2, x, y, xx, yy, xy, r2, r4, r6, rad;
    longint xr, yr, tx, ty;
    lsdm_pkg::out_t res;
    clip = 0;
    cx = longint'(centre_q[31:16]);
    cy = longint'(centre_q[15:0]);
    k1 = longint'($signed(coef_q[0]));
    k2 = longint'($signed(coef_q[1]));
    k3 = longint'($signed(coef_q[2]));
    p1 = longint'($signed(coef_q[3]));
    p2 = longint'($signed(coef_q[4]));
    x = norm_coord(longint'(pt.undist_x) - cx, focal_x_q, clip);
    y = norm_coord(longint'(pt.undist_y) - cy, focal_y_q, clip);
    r2 = round_half_up(x * x + y * y, lsdm_pkg::NORM_FRAC);
    xx = round_half_up(x * x, lsdm_pkg::NORM_FRAC);
    yy = round_half_up(y * y, lsdm_pkg::NORM_FRAC);
    xy = round_half_up(x * y, lsdm_pkg::NORM_FRAC);
    r4 = round_half_up(r2 * r2, lsdm_pkg::NORM_FRAC);
    r6 = round_half_up(r4 * r2, lsdm_pkg::NORM_FRAC);
    rad = (longint'(1) <<< lsdm_pkg::NORM_FRAC)
          + round_half_up(k1 * r2 + k2 * r4 + k3 * r6, lsdm_pkg::NORM_FRAC);
    xr = round_half_up(x * rad, lsdm_pkg::NORM_FRAC);
    yr = round_half_up(y * rad, lsdm_pkg::NORM_FRAC);
    tx = round_half_up(2 * p1 * xy + p2 * (r2 + 2 * xx), lsdm_pkg::NORM_FRAC);
    ty = round_half_up(p1 * (r2 + 2 * yy) + 2 * p2 * xy, lsdm_pkg::NORM_FRAC);
    res.dist_x = project_coord(xr + tx, focal_x_q, cx, clip);
    res.dist_y = project_coord(yr + ty, focal_y_q, cy, clip);
    res.clipped = clip;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    points_seen_o = 0;
    clipped_seen_o = 0;
  end

  // Track registers, predict on each input transaction, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin
    lsdm_pkg::out_t want;
    if (!rst_ni) begin
      focal_x_q <= lsdm_pkg::FOCAL_RESET;
      focal_y_q <= lsdm_pkg::FOCAL_RESET;
      centre_q  <= '0;
      for (int i = 0; i < 5; i++) coef_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (lsdm_pkg::cfg_idx_e'(cfg_idx_i))
          lsdm_pkg::CFG_FOCAL_X:   focal_x_q <= cfg_data_i[lsdm_pkg::FOCAL_W-1:0];
          lsdm_pkg::CFG_FOCAL_Y:   focal_y_q <= cfg_data_i[lsdm_pkg::FOCAL_W-1:0];
          lsdm_pkg::CFG_PRINCIPAL: centre_q  <= cfg_data_i;
          lsdm_pkg::CFG_K1:        coef_q[0] <= cfg_data_i[lsdm_pkg::COEF_W-1:0];
          lsdm_pkg::CFG_K2:        coef_q[1] <= cfg_data_i[lsdm_pkg::COEF_W-1:0];
          lsdm_pkg::CFG_K3:        coef_q[2] <= cfg_data_i[lsdm_pkg::COEF_W-1:0];
          lsdm_pkg::CFG_P1:        coef_q[3] <= cfg_data_i[lsdm_pkg::COEF_W-1:0];
          lsdm_pkg::CFG_P2:        coef_q[4] <= cfg_data_i[lsdm_pkg::COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_points.insert(expected_points.size(), distort_point(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        points_seen_o++;
        if (expected_points.size() == 0) begin
          $display("[%0t] result transaction with no point pending", $realtime);
          fail_count_o++;
        end else begin
          want = expected_points.pop_front();
          if (want.clipped) clipped_seen_o++;
          if (out_data_i.dist_x !== want.dist_x)
            report_mismatch("dist_x", out_data_i.dist_x, want.dist_x);
          if (out_data_i.dist_y !== want.dist_y)
            report_mismatch("dist_y", out_data_i.dist_y, want.dist_y);
          if (out_data_i.clipped !== want.clipped)
            report_mismatch("clipped", out_data_i.clipped, want.clipped);
        end
      end
      pending_o = expected_points.size();
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lens distortion point map testbench
// Drives points under several lens settings with random gaps and stalls; the
// checker predicts and compares every distorted point.
// ----------------------------------------------------------------------------
module tb;

  localparam int LATENCY = 38;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                           clk_i, rst_ni;
  logic                           cfg_we_i;
  logic [lsdm_pkg::REG_IDX_W-1:0] cfg_idx_i;
  logic [lsdm_pkg::CFG_W-1:0]     cfg_data_i;
  logic                           in_valid_i, in_ready_o;
  lsdm_pkg::in_t                  in_data_i;
  logic                           out_valid_o, out_ready_i;
  lsdm_pkg::out_t                 out_data_o;
  int                             fail_count, pending, points_seen, clipped_seen;
  int                             idle_cycles;

  lens_distortion_point_map DUT (.*);

  lsdm_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .points_seen_o(points_seen), .clipped_seen_o(clipped_seen)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly short stalls, a few long ones, and stretches of none
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
      if ($urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap_len()) @(negedge clk_i);
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Hold the write enable high; the caller drops it after the last write
  task automatic write_reg(lsdm_pkg::cfg_idx_e idx, logic [lsdm_pkg::CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // Drop valid, hold until every pending point is back, then let the pipeline settle
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Keep valid high after acceptance; the next call either reloads or drops it
  task automatic send_point(logic signed [15:0] ux, logic signed [15:0] uy, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{undist_x: ux, undist_y: uy};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic load_lens(logic [23:0] fx, logic [23:0] fy, logic [31:0] pp,
                           logic [23:0] k1, logic [23:0] k2, logic [23:0] k3,
                           logic [23:0] p1, logic [23:0] p2);
    write_reg(lsdm_pkg::CFG_FOCAL_X, lsdm_pkg::CFG_W'(fx));
    write_reg(lsdm_pkg::CFG_FOCAL_Y, lsdm_pkg::CFG_W'(fy));
    write_reg(lsdm_pkg::CFG_PRINCIPAL, pp);
    write_reg(lsdm_pkg::CFG_K1, lsdm_pkg::CFG_W'(k1));
    write_reg(lsdm_pkg::CFG_K2, lsdm_pkg::CFG_W'(k2));
    write_reg(lsdm_pkg::CFG_K3, lsdm_pkg::CFG_W'(k3));
    write_reg(lsdm_pkg::CFG_P1, lsdm_pkg::CFG_W'(p1));
    write_reg(lsdm_pkg::CFG_P2, lsdm_pkg::CFG_W'(p2));
    cfg_we_i <= 1'b0;
  endtask

  // Random point: mostly near the origin, sometimes anywhere
  task automatic random_points(int count);
    logic signed [15:0] ux, uy;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        ux = 16'($urandom());
        uy = 16'($urandom());
      end else begin
        ux = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
        uy = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
      end
      send_point(ux, uy, $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    logic [23:0] k1_rnd, p2_rnd;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    idle_cycles = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset lens, field extremes, zero point
    send_point(16'sh7FFF, 16'sh7FFF, 0);
    send_point(-16'sh8000, -16'sh8000, 0);
    send_point(16'sh7FFF, -16'sh8000, 0);
    send_point(16'sd0, 16'sd0, 0);
    send_point(16'sd1, -16'sd1, 0);
    drain_pipeline();

    // Strong distortion with a typical camera; the field extreme clamps the normal coords
    load_lens(24'd128000, 24'd120000, {16'd5120, 16'd3840},
              24'hF80000, 24'h040000, 24'hFF0000, 24'h001000, 24'hFFF000);
    send_point(16'sd0, 16'sd0, 0);
    send_point(16'sd5120, 16'sd3840, 0);
    send_point(16'sd10240, 16'sd7680, 0);
    send_point(16'sh7FFF, -16'sh8000, 0);
    drain_pipeline();
    // Zero focal length counts as one; all coefficients at their extremes
    load_lens(24'd0, 24'd1, 32'hFFFF_FFFF,
              24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_point(16'sd0, 16'sd0, 0);
    send_point(16'sh7FFF, 16'sh7FFF, 0);
    send_point(-16'sh8000, 16'sd1, 0);
    drain_pipeline();
    load_lens(24'hFFFFFF, 24'hFFFFFF, 32'h0000_0000,
              24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_point(16'sh7FFF, 16'sh7FFF, 0);
    send_point(-16'sh8000, -16'sh8000, 0);
    drain_pipeline();

    // Random phases, each under a random lens but the last, which uses the reset lens
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 6) begin
        load_lens(24'd128000, 24'd128000, 32'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      end else begin
        k1_rnd = $urandom_range(0, 1) ? 24'($urandom())
                 : 24'($signed($urandom_range(0, 1048575)) - 524288);
        p2_rnd = $urandom_range(0, 1) ? 24'($urandom()) : 24'h000400;
        load_lens(24'($urandom_range(2000, 400000)), 24'($urandom_range(2000, 400000)),
                  $urandom(), k1_rnd, 24'($urandom()), 24'($urandom()), p2_rnd,
                  24'($urandom()));
      end
      random_points(100);
      drain_pipeline();
    end

    repeat (LATENCY + 10) @(negedge clk_i);
    $display("run covered %0d points under several lens settings, %0d of them clipped",
             points_seen, clipped_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures, %0d points missing", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lsdm_pkg.sv
design/lsdm_div.sv
design/lsdm_poly.sv
design/lsdm_proj.sv
design/lens_distortion_point_map.sv
dv/lsdm_checker.sv
dv/tb.sv
